// ===== hw/rtl/ldfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ldfc_pkg
// Shared types and constants of the letter and digraph frequency counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ldfc_pkg;

   localparam int CHAR_W     = 8;
   localparam int KEY_W      = 2 * CHAR_W;
   localparam int LETTERS    = 52;
   localparam int BIN_W      = 6;
   localparam int LTOT_W     = 16;
   localparam int SLOT_W     = 9;
   localparam int USED_OUT_W = 10;

   localparam logic [CHAR_W-1:0] UPPER_A    = 8'h41;
   localparam logic [CHAR_W-1:0] UPPER_Z    = 8'h5A;
   localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;
   localparam logic [CHAR_W-1:0] LOWER_Z    = 8'h7A;
   localparam logic [CHAR_W-1:0] LOWER_BASE = 8'd26;

   // Control flags of one word as it moves down the table chain.
   typedef struct packed {
      logic valid;
      logic is_letter;
      logic search;
      logic found;
      logic created;
   } tok_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/letter_digraph_frequency_counter_top.sv =====
// ----------------------------------------------------------------------------
// letter_digraph_frequency_counter_top
// Counts letters and letter digraphs of a byte stream, one word per byte.
// ----------------------------------------------------------------------------
// Usage:
//   A byte is taken on req_char_code at a rising edge where start is high and
//   busy is low. busy is high only while reset is applied and in the cycle
//   right after it, so a byte may be offered in every cycle.
//   Each byte gives exactly one result word, shown on the rsp_ ports for one
//   cycle with rsp_strobe high; results leave in the order bytes came in.
//   The result appears once the word has passed the letter decode and histogram
//   update registers and then the register of each table entry in turn, as the
//   word walks the chain of entries. Throughput is one byte per cycle.
//   The receiver takes every result as it is shown; there is no stall.
//   Reset clears the letter histogram, the previous letter and the table
//   fill, and drops any bytes still in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module letter_digraph_frequency_counter_top #(
   parameter int TABLE_DEPTH = 512,
   parameter int COUNT_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ldfc_pkg::CHAR_W-1:0]          req_char_code,
   output logic                                 rsp_strobe,
   output logic                                 rsp_is_letter,
   output logic [ldfc_pkg::LTOT_W-1:0]          rsp_letter_total,
   output logic                                 rsp_pair_seen,
   output logic [ldfc_pkg::SLOT_W-1:0]          rsp_pair_slot,
   output logic [ldfc_pkg::LTOT_W-1:0]          rsp_pair_total,
   output logic                                 rsp_pair_created,
   output logic                                 rsp_pair_dropped,
   output logic [ldfc_pkg::USED_OUT_W-1:0]      rsp_slots_used
);

   localparam int IdxW     = $clog2(TABLE_DEPTH);
   localparam int UsedW    = $clog2(TABLE_DEPTH + 1);
   localparam int LtotW    = ldfc_pkg::LTOT_W;
   localparam int SlotW    = ldfc_pkg::SLOT_W;
   localparam int UsedOutW = ldfc_pkg::USED_OUT_W;

   logic                        busy_ff;
   logic                        take;
   ldfc_pkg::tok_ctl_type       ctl_chain   [TABLE_DEPTH + 1];
   logic [ldfc_pkg::KEY_W-1:0]  key_chain   [TABLE_DEPTH + 1];
   logic [IdxW-1:0]             slot_chain  [TABLE_DEPTH + 1];
   logic [COUNT_BITS-1:0]       total_chain [TABLE_DEPTH + 1];
   logic [UsedW-1:0]            used_chain  [TABLE_DEPTH + 1];
   logic [COUNT_BITS-1:0]       ltot_chain  [TABLE_DEPTH + 1];
   ldfc_pkg::tok_ctl_type       tail_ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;
   assign take = start && !busy_ff;

   ldfc_hist #(
      .COUNT_BITS (COUNT_BITS)
   ) u_hist (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .char_code   (req_char_code),
      .tok_ctl_ff  (ctl_chain[0]),
      .tok_key_ff  (key_chain[0]),
      .tok_ltot_ff (ltot_chain[0])
   );

   assign slot_chain[0]  = '0;
   assign total_chain[0] = '0;
   assign used_chain[0]  = '0;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_chain
      ldfc_cell #(
         .COUNT_BITS (COUNT_BITS),
         .IDX_W      (IdxW),
         .USED_W     (UsedW),
         .IDX        (g)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .ctl_i    (ctl_chain[g]),
         .key_i    (key_chain[g]),
         .slot_i   (slot_chain[g]),
         .total_i  (total_chain[g]),
         .used_i   (used_chain[g]),
         .ltot_i   (ltot_chain[g]),
         .ctl_ff   (ctl_chain[g + 1]),
         .key_ff   (key_chain[g + 1]),
         .slot_ff  (slot_chain[g + 1]),
         .total_ff (total_chain[g + 1]),
         .used_ff  (used_chain[g + 1]),
         .ltot_ff  (ltot_chain[g + 1])
      );
   end

   assign tail_ctl = ctl_chain[TABLE_DEPTH];

   // A word that searched and never found or claimed an entry was dropped.
   always_comb begin
      rsp_strobe       = tail_ctl.valid;
      rsp_is_letter    = tail_ctl.is_letter;
      rsp_letter_total = LtotW'(ltot_chain[TABLE_DEPTH]);
      rsp_pair_seen    = tail_ctl.search;
      rsp_pair_slot    = tail_ctl.found ? SlotW'(slot_chain[TABLE_DEPTH]) : '0;
      rsp_pair_total   = tail_ctl.found ? LtotW'(total_chain[TABLE_DEPTH]) : '0;
      rsp_pair_created = tail_ctl.created;
      rsp_pair_dropped = tail_ctl.search && !tail_ctl.found;
      rsp_slots_used   = UsedOutW'(used_chain[TABLE_DEPTH]);
   end

   a_nonletter_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_is_letter) |->
         (!rsp_pair_seen && (rsp_letter_total == '0)))
      else $error("non-letter word carries letter or pair data");

   a_created_count_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_pair_created) |->
         (!rsp_pair_dropped && (rsp_pair_total == LtotW'(1))))
      else $error("new pair entry without a count of one");

   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_pair_dropped) |->
         (rsp_slots_used == UsedOutW'(TABLE_DEPTH)))
      else $error("pair dropped while the table has free entries");

endmodule

`default_nettype wire

// ===== hw/rtl/ldfc_hist.sv =====
// ----------------------------------------------------------------------------
// ldfc_hist
// Entry stages: letter decode, digraph key build and the letter histogram.
// ----------------------------------------------------------------------------
`default_nettype none

module ldfc_hist #(
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            take,
   input  logic [ldfc_pkg::CHAR_W-1:0]     char_code,
   output ldfc_pkg::tok_ctl_type           tok_ctl_ff,
   output logic [ldfc_pkg::KEY_W-1:0]      tok_key_ff,
   output logic [COUNT_BITS-1:0]           tok_ltot_ff
);

   localparam int BinW    = ldfc_pkg::BIN_W;
   localparam int Letters = ldfc_pkg::LETTERS;

   logic                          is_upper;
   logic                          is_lower;
   logic                          is_letter;
   logic [BinW-1:0]               bin;
   ldfc_pkg::tok_ctl_type         s1_ctl_in;
   ldfc_pkg::tok_ctl_type         s1_ctl_ff;
   logic [BinW-1:0]               s1_bin_ff;
   logic [ldfc_pkg::KEY_W-1:0]    s1_key_ff;
   logic [ldfc_pkg::CHAR_W-1:0]   prev_letter_ff;
   logic                          prev_valid_ff;
   logic [COUNT_BITS-1:0]         hist_mem [Letters];
   logic [Letters-1:0]            hv_ff;
   logic [COUNT_BITS-1:0]         rd_data_ff;
   logic                          rd_valid_ff;
   logic                          wr_valid_ff;
   logic [BinW-1:0]               wr_bin_ff;
   logic [COUNT_BITS-1:0]         wr_data_ff;
   logic [COUNT_BITS-1:0]         cur;
   logic [COUNT_BITS-1:0]         cnt_in;
   logic                          hist_we;

   always_comb begin
      is_upper  = (char_code >= ldfc_pkg::UPPER_A) && (char_code <= ldfc_pkg::UPPER_Z);
      is_lower  = (char_code >= ldfc_pkg::LOWER_A) && (char_code <= ldfc_pkg::LOWER_Z);
      is_letter = is_upper || is_lower;
      if (is_upper) begin
         bin = BinW'(char_code - ldfc_pkg::UPPER_A);
      end else begin
         bin = BinW'(char_code - ldfc_pkg::LOWER_A + ldfc_pkg::LOWER_BASE);
      end
      s1_ctl_in           = '0;
      s1_ctl_in.valid     = take;
      s1_ctl_in.is_letter = take && is_letter;
      s1_ctl_in.search    = take && is_letter && prev_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff      <= '0;
         prev_valid_ff  <= 1'b0;
         prev_letter_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
         if (take && is_letter) begin
            prev_valid_ff  <= 1'b1;
            prev_letter_ff <= char_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_bin_ff <= bin;
      s1_key_ff <= {prev_letter_ff, char_code};
   end

   // The read for a word is issued as it is accepted, at the same edge at
   // which the word ahead writes back, so the last write is forwarded.
   assign hist_we = s1_ctl_ff.valid && s1_ctl_ff.is_letter;

   always_comb begin
      if (wr_valid_ff && (wr_bin_ff == s1_bin_ff)) begin
         cur = wr_data_ff;
      end else if (rd_valid_ff) begin
         cur = rd_data_ff;
      end else begin
         cur = '0;
      end
      cnt_in = (cur == '1) ? cur : cur + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[s1_bin_ff] <= cnt_in;
      end
      rd_data_ff  <= hist_mem[bin];
      rd_valid_ff <= hv_ff[bin];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff       <= '0;
         wr_valid_ff <= 1'b0;
         tok_ctl_ff  <= '0;
      end else begin
         tok_ctl_ff <= s1_ctl_ff;
         if (hist_we) begin
            hv_ff[s1_bin_ff] <= 1'b1;
            wr_valid_ff      <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         wr_bin_ff  <= s1_bin_ff;
         wr_data_ff <= cnt_in;
      end
      tok_key_ff  <= s1_key_ff;
      tok_ltot_ff <= hist_we ? cnt_in : '0;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ldfc_cell.sv =====
// ----------------------------------------------------------------------------
// ldfc_cell
// One digraph table entry; matches, counts or claims for the passing word.
// ----------------------------------------------------------------------------
`default_nettype none

module ldfc_cell #(
   parameter int COUNT_BITS = 16,
   parameter int IDX_W      = 9,
   parameter int USED_W     = 10,
   parameter int IDX        = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ldfc_pkg::tok_ctl_type        ctl_i,
   input  logic [ldfc_pkg::KEY_W-1:0]   key_i,
   input  logic [IDX_W-1:0]             slot_i,
   input  logic [COUNT_BITS-1:0]        total_i,
   input  logic [USED_W-1:0]            used_i,
   input  logic [COUNT_BITS-1:0]        ltot_i,
   output ldfc_pkg::tok_ctl_type        ctl_ff,
   output logic [ldfc_pkg::KEY_W-1:0]   key_ff,
   output logic [IDX_W-1:0]             slot_ff,
   output logic [COUNT_BITS-1:0]        total_ff,
   output logic [USED_W-1:0]            used_ff,
   output logic [COUNT_BITS-1:0]        ltot_ff
);

   logic [ldfc_pkg::KEY_W-1:0] ent_key_ff;
   logic [COUNT_BITS-1:0]      ent_cnt_ff;
   logic                       ent_valid_ff;
   logic                       probe;
   logic                       hit;
   logic                       claim;
   logic [COUNT_BITS-1:0]      inc;
   ldfc_pkg::tok_ctl_type      ctl_in;
   logic [IDX_W-1:0]           slot_in;
   logic [COUNT_BITS-1:0]      total_in;
   logic [USED_W-1:0]          used_in;

   // Entries fill from index zero upward, so the first empty entry that an
   // unresolved word meets is the place where its new pair goes.
   always_comb begin
      probe = ctl_i.valid && ctl_i.search && !ctl_i.found;
      hit   = probe && ent_valid_ff && (ent_key_ff == key_i);
      claim = probe && !ent_valid_ff;
      inc   = (ent_cnt_ff == '1) ? ent_cnt_ff : ent_cnt_ff + 1'b1;

      ctl_in         = ctl_i;
      ctl_in.found   = ctl_i.found || hit || claim;
      ctl_in.created = ctl_i.created || claim;
      slot_in        = (hit || claim) ? IDX_W'(IDX) : slot_i;
      if (hit) begin
         total_in = inc;
      end else if (claim) begin
         total_in = COUNT_BITS'(1);
      end else begin
         total_in = total_i;
      end
      used_in = (ent_valid_ff || claim) ? USED_W'(IDX + 1) : used_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
         ctl_ff       <= '0;
      end else begin
         ctl_ff <= ctl_in;
         if (claim) begin
            ent_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (claim) begin
         ent_key_ff <= key_i;
      end
      if (hit || claim) begin
         ent_cnt_ff <= claim ? COUNT_BITS'(1) : inc;
      end
      key_ff   <= key_i;
      slot_ff  <= slot_in;
      total_ff <= total_in;
      used_ff  <= used_in;
      ltot_ff  <= ltot_i;
   end

   a_claim_at_fill_edge: assert property (@(posedge clock) disable iff (reset)
      claim |-> (used_i == USED_W'(IDX)))
      else $error("entry claimed away from the end of the filled region");

endmodule

`default_nettype wire
